// File: sv/ntfp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ntfp_pkg
// Types and constants shared by the NMEA time field parser modules.
// ----------------------------------------------------------------------------
package ntfp_pkg;

	// character codes
	localparam logic [7:0] CHAR_ZERO = 8'h30;
	localparam logic [7:0] CHAR_NINE = 8'h39;
	localparam logic [7:0] CHAR_DOT  = 8'h2E;

	// field layout and range limits
	localparam logic [2:0] POS_DOT       = 3'd6;
	localparam logic [2:0] POS_FRACTION  = 3'd7;
	localparam logic [2:0] POS_HOUR_LO   = 3'd1;
	localparam logic [2:0] POS_MINUTE_LO = 3'd3;
	localparam logic [6:0] HOUR_LIMIT    = 7'd23;
	localparam logic [6:0] MIN_SEC_LIMIT = 7'd59;

	// running state of one field
	typedef struct packed {
		logic [2:0]  char_position;   // saturates at the fraction position
		logic [6:0]  pair_accum;
		logic [4:0]  hour_reg;
		logic [5:0]  minute_reg;
		logic [5:0]  second_reg;
		logic [29:0] fraction_accum;
		logic [3:0]  digit_count;
		logic        error_flag;
	} field_state_t;

	// one parsed time result
	typedef struct packed {
		logic        time_ok;
		logic [4:0]  hour_value;
		logic [5:0]  minute_value;
		logic [5:0]  second_value;
		logic [29:0] fraction_value;
		logic [3:0]  fraction_digits;
	} time_result_t;

endpackage
`default_nettype wire

// File: sv/ntfp_char_step.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ntfp_char_step
// Applies one character to the field state and forms the result that a
// final character produces.
// ----------------------------------------------------------------------------
module ntfp_char_step #(
	parameter int MAX_FRACTION_DIGITS = 9
) (
	input  wire ntfp_pkg::field_state_t state,
	input  wire logic [7:0]             char_code,
	input  wire logic                   last_char,
	output ntfp_pkg::field_state_t      next_state,
	output ntfp_pkg::time_result_t      result
);

	logic                   is_digit;
	logic [3:0]             digit;
	logic [6:0]             pair_sum;
	logic [6:0]             pair_limit;
	logic [2:0]             pos;
	logic [2:0]             pos_next;
	ntfp_pkg::field_state_t upd;
	logic                   ok;

	// digit decode
	assign is_digit = (char_code >= ntfp_pkg::CHAR_ZERO) && (char_code <= ntfp_pkg::CHAR_NINE);
	assign digit    = is_digit ? 4'(char_code - ntfp_pkg::CHAR_ZERO) : 4'd0;
	assign pos      = state.char_position;
	assign pair_sum = state.pair_accum + 7'(digit);
	assign pair_limit = (pos == ntfp_pkg::POS_HOUR_LO) ? ntfp_pkg::HOUR_LIMIT
	                                                   : ntfp_pkg::MIN_SEC_LIMIT;
	assign pos_next = (pos < ntfp_pkg::POS_FRACTION) ? pos + 3'd1 : pos;

	// field state update for this character
	always_comb begin
		upd = state;
		upd.char_position = pos_next;
		if (!state.error_flag) begin
			if (pos < ntfp_pkg::POS_DOT) begin
				if (!is_digit) begin
					upd.error_flag = 1'b1;
				end else if (!pos[0]) begin
					// tens digit times ten
					upd.pair_accum = 7'({digit, 3'b000}) + 7'({digit, 1'b0});
				end else if (pair_sum > pair_limit) begin
					upd.error_flag = 1'b1;
				end else if (pos == ntfp_pkg::POS_HOUR_LO) begin
					upd.hour_reg = 5'(pair_sum);
				end else if (pos == ntfp_pkg::POS_MINUTE_LO) begin
					upd.minute_reg = 6'(pair_sum);
				end else begin
					upd.second_reg = 6'(pair_sum);
				end
			end else if (pos == ntfp_pkg::POS_DOT) begin
				if (char_code != ntfp_pkg::CHAR_DOT) begin
					upd.error_flag = 1'b1;
				end
			end else begin
				if (!is_digit || (state.digit_count >= 4'(MAX_FRACTION_DIGITS))) begin
					upd.error_flag = 1'b1;
				end else begin
					upd.fraction_accum = {state.fraction_accum[26:0], 3'b000}
					                   + {state.fraction_accum[28:0], 1'b0}
					                   + 30'(digit);
					upd.digit_count = state.digit_count + 4'd1;
				end
			end
		end
	end

	// result on the final character, field state cleared after it
	assign ok = !upd.error_flag && ((pos_next == ntfp_pkg::POS_DOT) ||
	            ((pos_next == ntfp_pkg::POS_FRACTION) && (upd.digit_count != 4'd0)));

	always_comb begin
		result.time_ok         = ok;
		result.hour_value      = ok ? upd.hour_reg       : 5'd0;
		result.minute_value    = ok ? upd.minute_reg     : 6'd0;
		result.second_value    = ok ? upd.second_reg     : 6'd0;
		result.fraction_value  = ok ? upd.fraction_accum : 30'd0;
		result.fraction_digits = ok ? upd.digit_count    : 4'd0;
		next_state = last_char ? '0 : upd;
	end

endmodule
`default_nettype wire

// File: sv/ntfp_out_reg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ntfp_out_reg
// Result register on the output channel; holds a result while stalled.
// ----------------------------------------------------------------------------
module ntfp_out_reg (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   load,
	input  wire ntfp_pkg::time_result_t load_result,
	input  wire logic                   out_stall,
	output logic                        out_valid,
	output ntfp_pkg::time_result_t      result_q
);

	logic valid_q;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (load) begin
			result_q <= load_result;
		end
	end

	assign out_valid = valid_q;

endmodule
`default_nettype wire

// File: sv/nmea_time_field_parser_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nmea_time_field_parser_core
// Parses an NMEA hhmmss[.f...] time field one character per transfer.
// ----------------------------------------------------------------------------
// Takes one character per cycle unless the input stalls; each character
// goes through an input register, then one step of digit check, range
// check and multiply-by-ten accumulate updates the field state. The final
// character of a field loads the result register from that step, and a new
// character may enter the input register meanwhile. Input stalls only when a
// final character waits behind a result the output side has not yet taken.
// Time fields are zero whenever time_ok is low.
// ----------------------------------------------------------------------------
module nmea_time_field_parser_core #(
	parameter int MAX_FRACTION_DIGITS = 9
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  char_code,
	input  wire logic        last_char,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             time_ok,
	output logic [4:0]       hour_value,
	output logic [5:0]       minute_value,
	output logic [5:0]       second_value,
	output logic [29:0]      fraction_value,
	output logic [3:0]       fraction_digits
);

	logic                   valid_s1;
	logic [7:0]             char_s1;
	logic                   last_s1;
	logic                   advance_s1;
	ntfp_pkg::field_state_t state_q;
	ntfp_pkg::field_state_t state_next;
	ntfp_pkg::time_result_t step_result;
	ntfp_pkg::time_result_t out_result;

	// stage 1 moves on unless a final character meets a held result
	assign advance_s1 = valid_s1 && (!last_s1 || !out_valid || !out_stall);
	assign in_stall   = valid_s1 && !advance_s1;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			char_s1 <= char_code;
			last_s1 <= last_char;
		end
	end

	// character step
	ntfp_char_step #(
		.MAX_FRACTION_DIGITS(MAX_FRACTION_DIGITS)
	) u_step (
		.state      (state_q),
		.char_code  (char_s1),
		.last_char  (last_s1),
		.next_state (state_next),
		.result     (step_result)
	);

	// field state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance_s1) begin
			state_q <= state_next;
		end
	end

	// result register
	ntfp_out_reg u_out (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (advance_s1 && last_s1),
		.load_result (step_result),
		.out_stall   (out_stall),
		.out_valid   (out_valid),
		.result_q    (out_result)
	);

	assign time_ok         = out_result.time_ok;
	assign hour_value      = out_result.hour_value;
	assign minute_value    = out_result.minute_value;
	assign second_value    = out_result.second_value;
	assign fraction_value  = out_result.fraction_value;
	assign fraction_digits = out_result.fraction_digits;

`ifndef SYNTH
	// rejected fields carry zero values
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !time_ok |-> hour_value == 5'd0 && minute_value == 6'd0 &&
		second_value == 6'd0 && fraction_value == 30'd0 && fraction_digits == 4'd0)
		else $error("rejected field with nonzero values");

	// accepted fields are in range
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && time_ok |-> hour_value <= 5'd23 && minute_value <= 6'd59 &&
		second_value <= 6'd59 && fraction_digits <= 4'(MAX_FRACTION_DIGITS))
		else $error("accepted field out of range");

	// a final character leaves a clean field state
	assert property (@(posedge clk) disable iff (!arst_n)
		advance_s1 && last_s1 |=> state_q == '0 && out_valid)
		else $error("field state not cleared after final character");
`endif

endmodule
`default_nettype wire
